@@ design/kpht_pkg.sv @@
package kpht_pkg;

  // Key table size and derived index width
  localparam int unsigned NUM_KEYS = 256;
  localparam int unsigned IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_KEYS - 1);

  // Field widths
  localparam int unsigned OP_W = 2;
  localparam int unsigned KEY_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned FRAME_W = 15;

  // Saturation point of the frames-held count
  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

  // Operation codes; code 3 is unused and ignored
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_EVENT = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Per-key record held in the key memory
  typedef struct packed {
    logic               act;
    logic               pf;
    logic               rf;
    logic [FRAME_W-1:0] fc;
  } key_rec_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_RD,
    S_TICK_WR,
    S_EVENT,
    S_Q_DIFF,
    S_Q_CMP,
    S_CLEAR
  } state_e;

endpackage

@@ design/kpht_in_if.sv @@
interface kpht_in_if;
  logic                          valid;
  logic                          ready;
  logic [kpht_pkg::OP_W-1:0]     op;
  logic [kpht_pkg::KEY_W-1:0]    key;
  logic                          key_down;
  logic [kpht_pkg::TIME_W-1:0]   now;
  logic [kpht_pkg::TIME_W-1:0]   hold_threshold;

  modport source (output valid, op, key, key_down, now, hold_threshold, input ready);
  modport sink (input valid, op, key, key_down, now, hold_threshold, output ready);
endinterface

@@ design/kpht_out_if.sv @@
interface kpht_out_if;
  logic                          valid;
  logic                          ready;
  logic                          pressed_now;
  logic                          released_now;
  logic                          held;
  logic                          held_long;
  logic [kpht_pkg::FRAME_W-1:0]  frames_held;

  modport source (output valid, pressed_now, released_now, held, held_long, frames_held,
                  input ready);
  modport sink (input valid, pressed_now, released_now, held, held_long, frames_held,
                output ready);
endinterface

@@ design/key_press_hold_release_tracker.sv @@
// Key press / hold / release tracker.
// in_i carries one word per operation: a frame tick, a key event (key_down
// 1 press, 0 release) or a status query for one key. Only queries produce a
// word on out_o; ticks, events and the unused op code produce nothing.
// Sequencing, from the accepting edge until in_i.ready is high again:
//   key event: one S_EVENT step; unused op: none, in_i.ready stays high.
//   query: steps S_Q_DIFF and S_Q_CMP; the status word is loaded into the
//     output register at the end of S_Q_CMP and is then valid on out_o.
//   frame tick: an S_TICK_RD / S_TICK_WR pair per key; the sweep reads and
//     rewrites each key's record (active mark, press and release flags, frame
//     count) through the record memory and the shared 33-bit adder.
// The adder also forms now - press time and compares it to the threshold,
// one pass per cycle, so a query needs both of its steps.
// A status word waits in the output register while out_o.ready is low; ticks
// and events are still taken, and a following query holds in its last step
// until the register frees up.
// After reset a clearing pass writes an idle record to every key and holds
// in_i.ready low while it runs; the press-time memory needs no clearing,
// since a key's entry is only used while it is active.
module key_press_hold_release_tracker (
  input  logic         clk_i,
  input  logic         rst_ni,
  kpht_in_if.sink      in_i,
  kpht_out_if.source   out_o
);

  kpht_pkg::state_e state_q, state_d;

  // Sweep index
  logic [kpht_pkg::IDX_W-1:0] idx_q, idx_d;

  // Captured input word
  logic                          down_q;
  logic                          key_ok_q;
  logic [kpht_pkg::IDX_W-1:0]    key_idx_q;
  logic [kpht_pkg::TIME_W-1:0]   now_q;
  logic [kpht_pkg::TIME_W-1:0]   thr_q;
  logic [kpht_pkg::IDX_W-1:0]    in_key_idx;
  logic                          in_key_ok;
  logic                          in_acc;

  // Memories
  kpht_pkg::key_rec_t           rec_mem [kpht_pkg::NUM_KEYS];
  logic [kpht_pkg::TIME_W-1:0]  pt_mem [kpht_pkg::NUM_KEYS];
  kpht_pkg::key_rec_t           rec_rd_q;
  logic [kpht_pkg::TIME_W-1:0]  pt_rd_q;
  logic [kpht_pkg::IDX_W-1:0]   rd_idx;
  logic [kpht_pkg::IDX_W-1:0]   rec_wa;
  logic                         rec_we;
  kpht_pkg::key_rec_t           rec_wd;
  logic                         pt_we;

  // Shared adder: a + b + 1
  logic [kpht_pkg::TIME_W-1:0] alu_a, alu_b;
  logic [kpht_pkg::TIME_W:0]   alu_sum;

  // Query intermediate results
  logic [kpht_pkg::TIME_W-1:0] diff_q, diff_d;
  logic                        ge_q, ge_d;

  // Output register
  logic                         out_valid_q, out_valid_d;
  logic                         load_out;
  logic                         pn_q, rn_q, hd_q, hl_q;
  logic [kpht_pkg::FRAME_W-1:0] fh_q;
  logic                         res_act, res_pn, res_rn, res_hd, res_hl;
  logic [kpht_pkg::FRAME_W-1:0] res_fh;

  assign in_key_idx = kpht_pkg::IDX_W'(in_i.key);
  assign in_key_ok  = 32'(in_i.key) < kpht_pkg::NUM_KEYS;
  assign in_acc     = in_i.valid && in_i.ready;

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + 33'd1;

  // Query status from the key record and the two adder passes
  assign res_act = key_ok_q && rec_rd_q.act;
  assign res_pn  = res_act && rec_rd_q.pf && (rec_rd_q.fc == '0);
  assign res_rn  = key_ok_q && rec_rd_q.rf;
  assign res_hd  = res_act && (rec_rd_q.fc != '0);
  assign res_hl  = res_hd && ge_q && !alu_sum[kpht_pkg::TIME_W];
  assign res_fh  = res_act ? rec_rd_q.fc : '0;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    diff_d      = diff_q;
    ge_d        = ge_q;
    rd_idx      = key_idx_q;
    rec_wa      = key_idx_q;
    rec_we      = 1'b0;
    rec_wd      = '0;
    pt_we       = 1'b0;
    alu_a       = kpht_pkg::TIME_W'(rec_rd_q.fc);
    alu_b       = '0;
    load_out    = 1'b0;
    in_i.ready  = 1'b0;
    unique case (state_q)
      kpht_pkg::S_CLEAR: begin
        // idle record into every key after reset
        rec_wa = idx_q;
        rec_we = 1'b1;
        if (idx_q == kpht_pkg::LAST_IDX) begin
          idx_d   = '0;
          state_d = kpht_pkg::S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
        end
      end
      kpht_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        rd_idx     = in_key_idx;
        if (in_i.valid) begin
          unique case (in_i.op)
            kpht_pkg::OP_TICK: begin
              idx_d   = '0;
              state_d = kpht_pkg::S_TICK_RD;
            end
            kpht_pkg::OP_EVENT: state_d = kpht_pkg::S_EVENT;
            kpht_pkg::OP_QUERY: state_d = kpht_pkg::S_Q_DIFF;
            default: ;
          endcase
        end
      end
      kpht_pkg::S_TICK_RD: begin
        rd_idx  = idx_q;
        state_d = kpht_pkg::S_TICK_WR;
      end
      kpht_pkg::S_TICK_WR: begin
        // flags cleared, saturating increment of an active key
        rd_idx     = idx_q;
        rec_wa     = idx_q;
        rec_we     = 1'b1;
        rec_wd.act = rec_rd_q.act;
        if (rec_rd_q.act && (rec_rd_q.fc != kpht_pkg::FRAME_MAX)) begin
          rec_wd.fc = alu_sum[kpht_pkg::FRAME_W-1:0];
        end else begin
          rec_wd.fc = rec_rd_q.fc;
        end
        if (idx_q == kpht_pkg::LAST_IDX) begin
          idx_d   = '0;
          state_d = kpht_pkg::S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = kpht_pkg::S_TICK_RD;
        end
      end
      kpht_pkg::S_EVENT: begin
        if (key_ok_q) begin
          if (down_q) begin
            if (!rec_rd_q.act) begin
              rec_wd.act = 1'b1;
              rec_wd.pf  = 1'b1;
              rec_we     = 1'b1;
              pt_we      = 1'b1;
            end
          end else begin
            // release counts only after at least one tick
            rec_wd.rf = rec_rd_q.rf || (rec_rd_q.act && (rec_rd_q.fc != '0));
            rec_we    = 1'b1;
          end
        end
        state_d = kpht_pkg::S_IDLE;
      end
      kpht_pkg::S_Q_DIFF: begin
        // now - press time; carry out means no wrap
        alu_a   = now_q;
        alu_b   = ~pt_rd_q;
        diff_d  = alu_sum[kpht_pkg::TIME_W-1:0];
        ge_d    = alu_sum[kpht_pkg::TIME_W];
        state_d = kpht_pkg::S_Q_CMP;
      end
      kpht_pkg::S_Q_CMP: begin
        // threshold - diff; no carry means diff above threshold
        alu_a = thr_q;
        alu_b = ~diff_q;
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = kpht_pkg::S_IDLE;
        end
      end
      default: state_d = kpht_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kpht_pkg::S_CLEAR;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Captured word and query temporaries
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      down_q    <= in_i.key_down;
      key_ok_q  <= in_key_ok;
      key_idx_q <= in_key_idx;
      now_q     <= in_i.now;
      thr_q     <= in_i.hold_threshold;
    end
    diff_q <= diff_d;
    ge_q   <= ge_d;
  end

  // Key record and press time memories
  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    rec_rd_q <= rec_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[key_idx_q] <= now_q;
    pt_rd_q <= pt_mem[rd_idx];
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pn_q <= res_pn;
      rn_q <= res_rn;
      hd_q <= res_hd;
      hl_q <= res_hl;
      fh_q <= res_fh;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pressed_now  = pn_q;
  assign out_o.released_now = rn_q;
  assign out_o.held         = hd_q;
  assign out_o.held_long    = hl_q;
  assign out_o.frames_held  = fh_q;

  // Checks
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kpht_pkg::S_IDLE) |-> (idx_q == '0))
    else $error("sweep index not parked at zero");

  a_press_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_we |-> (!rec_wd.pf || rec_wd.act))
    else $error("press flag on an idle key");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == kpht_pkg::S_Q_CMP))
    else $error("status word without a query");

  a_long_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!hl_q || hd_q))
    else $error("held_long without held");

  a_frames_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((fh_q != '0) == hd_q) && !(pn_q && hd_q))
    else $error("frames_held inconsistent with held or pressed");

endmodule
